FILE: design/lcg_iterate_from_seed_assert.svh
// Assertion macros used by the top-level design file.
// Each macro checks one implication on the rising clock edge, with reset as the disable.
`ifndef LCG_ITERATE_FROM_SEED_ASSERT_SVH
`define LCG_ITERATE_FROM_SEED_ASSERT_SVH
`ifndef SYNTHESIS
`define LCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define LCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define LCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/lcg_pkg.sv
`timescale 1ns / 1ps

package lcg_pkg;

  // Width of every sequence value and of the modulus.
  localparam int VAL_W = 31;
  // Bits needed to index one bit of a value.
  localparam int IDX_W = $clog2(VAL_W);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MULT = 2'd0;
  localparam logic [1:0] REG_INC  = 2'd1;
  localparam logic [1:0] REG_MOD  = 2'd2;
  localparam logic [1:0] REG_SEED = 2'd3;

  // Register reset values.
  localparam logic [VAL_W-1:0] MULT_RESET = 31'd12312331;
  localparam logic [VAL_W-1:0] INC_RESET  = 31'd111;
  localparam logic [VAL_W-1:0] MOD_RESET  = 31'd2147483647;
  localparam logic [VAL_W-1:0] SEED_RESET = 31'd13;

  // Top-level sequencer: an idle state and one state for each kind of modular multiply-add it issues.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_MUL,
    ST_RED_INC,
    ST_RED_SEED,
    ST_BIT_RC,
    ST_BIT_RA,
    ST_SQ_BC,
    ST_SQ_BA,
    ST_FINAL
  } lcg_state_e;

  // Modular multiply-add unit phases.
  typedef enum logic [1:0] {
    MM_IDLE,
    MM_DBL,
    MM_ADD,
    MM_ADDC
  } mm_state_e;

  // Request to the unit: r = (a * b + c) mod m, with a and c below m.
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] c;
  } mm_req_t;

  // Response of the unit: done pulses for one cycle while r holds the result.
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] r;
  } mm_rsp_t;

endpackage

FILE: design/lcg_iterate_from_seed.sv
`timescale 1ns / 1ps
`include "lcg_iterate_from_seed_assert.svh"

// Linear congruential generator evaluated from the configured seed.
// Command channel: a transaction is taken when start is high and busy is low;
// step_count_i gives n. The result, the value after n steps of
// x = (multiplier * x + increment) mod modulus, appears on value_o for one
// cycle with valid_o high; the receiver cannot stall it, so nothing waits.
// Configuration: APB-style port, registers multiplier, increment, modulus and
// seed at byte addresses 0, 4, 8 and 12. The user must see that they are
// written only while busy is low; the block itself does not enforce it. A
// count of zero returns the unreduced seed in the cycle after the
// transaction. Otherwise the block jumps ahead by squaring the affine step
// map and issues 4 + 2*popcount(n) + 2*(L - 1) modular multiply-adds, L being
// the bit length of n. Each runs on one shared bit-serial unit.
// One item is worked on at a time; busy stays high until the result is shown.
// Reset restores the register reset values and aborts any item in progress.
module lcg_iterate_from_seed (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [lcg_pkg::VAL_W-1:0] step_count_i,
  output logic                     valid_o,
  output logic [lcg_pkg::VAL_W-1:0] value_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import lcg_pkg::*;

  lcg_state_e       state_q, state_d;
  logic             wait_q;
  logic             valid_q;
  logic [VAL_W-1:0] value_q;

  logic [VAL_W-1:0] mult_q, inc_q, mod_q, seed_q;
  logic [VAL_W-1:0] n_q, ra_q, rc_q, ba_q, bc_q, x_q;

  logic             accept;
  logic             cfg_wr;
  logic [31:0]      m_eff;
  logic [VAL_W-1:0] one_mod;
  mm_req_t          mm_req;
  mm_rsp_t          mm_rsp;

  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign value_o = value_q;

  // A zero modulus acts as 2^31; 1 mod m is zero only for a modulus of one.
  assign m_eff   = (mod_q == '0) ? 32'h8000_0000 : {1'b0, mod_q};
  assign one_mod = (mod_q == VAL_W'(1)) ? '0 : VAL_W'(1);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RESET;
      inc_q  <= INC_RESET;
      mod_q  <= MOD_RESET;
      seed_q <= SEED_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MULT: mult_q <= pwdata[VAL_W-1:0];
        REG_INC:  inc_q  <= pwdata[VAL_W-1:0];
        REG_MOD:  mod_q  <= pwdata[VAL_W-1:0];
        REG_SEED: seed_q <= pwdata[VAL_W-1:0];
      endcase
    end
  end

  // Configuration reads.
  always_comb begin
    unique case (paddr[3:2])
      REG_MULT: prdata = {1'b0, mult_q};
      REG_INC:  prdata = {1'b0, inc_q};
      REG_MOD:  prdata = {1'b0, mod_q};
      REG_SEED: prdata = {1'b0, seed_q};
    endcase
  end

  // Sequencer next state: leave idle on an accepted nonzero count, then advance when the shared unit reports done.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (step_count_i != '0)) begin
          state_d = ST_RED_MUL;
        end
      end
      ST_RED_MUL: begin
        if (mm_rsp.done) begin
          state_d = ST_RED_INC;
        end
      end
      ST_RED_INC: begin
        if (mm_rsp.done) begin
          state_d = ST_RED_SEED;
        end
      end
      ST_RED_SEED: begin
        if (mm_rsp.done) begin
          state_d = n_q[0] ? ST_BIT_RC : ST_SQ_BC;
        end
      end
      ST_BIT_RC: begin
        if (mm_rsp.done) begin
          state_d = ST_BIT_RA;
        end
      end
      ST_BIT_RA: begin
        if (mm_rsp.done) begin
          state_d = (n_q[VAL_W-1:1] == '0) ? ST_FINAL : ST_SQ_BC;
        end
      end
      ST_SQ_BC: begin
        if (mm_rsp.done) begin
          state_d = ST_SQ_BA;
        end
      end
      ST_SQ_BA: begin
        // The count is shifted here; its next low bit decides the next step.
        if (mm_rsp.done) begin
          state_d = n_q[1] ? ST_BIT_RC : ST_SQ_BC;
        end
      end
      ST_FINAL: begin
        if (mm_rsp.done) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Sequencer outputs: operands of the multiply-add issued in each state.
  always_comb begin
    mm_req.start = busy && !wait_q;
    mm_req.a     = ba_q;
    mm_req.b     = '0;
    mm_req.c     = '0;
    unique case (state_q)
      ST_IDLE: begin
        mm_req.a = '0;
      end
      ST_RED_MUL: begin
        mm_req.a = one_mod;
        mm_req.b = mult_q;
      end
      ST_RED_INC: begin
        mm_req.a = one_mod;
        mm_req.b = inc_q;
      end
      ST_RED_SEED: begin
        mm_req.a = one_mod;
        mm_req.b = seed_q;
      end
      ST_BIT_RC: begin
        mm_req.b = rc_q;
        mm_req.c = bc_q;
      end
      ST_BIT_RA: begin
        mm_req.b = ra_q;
      end
      ST_SQ_BC: begin
        mm_req.b = bc_q;
        mm_req.c = bc_q;
      end
      ST_SQ_BA: begin
        mm_req.b = ba_q;
      end
      ST_FINAL: begin
        mm_req.a = ra_q;
        mm_req.b = x_q;
        mm_req.c = rc_q;
      end
    endcase
  end

  lcg_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .m_i    (m_eff),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mm_req.start) begin
        wait_q <= 1'b1;
      end else if (mm_rsp.done) begin
        wait_q <= 1'b0;
      end
      valid_q <= (accept && (step_count_i == '0)) ||
                 ((state_q == ST_FINAL) && mm_rsp.done);
    end
  end

  // Jump-ahead map registers and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q  <= step_count_i;
      ra_q <= one_mod;
      rc_q <= '0;
      if (step_count_i == '0) begin
        value_q <= seed_q;
      end
    end
    if (mm_rsp.done) begin
      unique case (state_q)
        ST_IDLE:     ;
        ST_RED_MUL:  ba_q <= mm_rsp.r;
        ST_RED_INC:  bc_q <= mm_rsp.r;
        ST_RED_SEED: x_q  <= mm_rsp.r;
        ST_BIT_RC:   rc_q <= mm_rsp.r;
        ST_BIT_RA:   ra_q <= mm_rsp.r;
        ST_SQ_BC:    bc_q <= mm_rsp.r;
        ST_SQ_BA: begin
          ba_q <= mm_rsp.r;
          n_q  <= n_q >> 1;
        end
        ST_FINAL:    value_q <= mm_rsp.r;
      endcase
    end
  end

  // A result is shown only once the sequencer is back at rest.
  `LCG_ASSERT_IMP(a_valid_idle, clk_i, rst_ni, valid_o, !busy)
  // A zero count returns the seed in the next cycle.
  `LCG_ASSERT_NXT(a_zero_seed, clk_i, rst_ni, accept && (step_count_i == '0), valid_o && (value_o == $past(seed_q)))
  // A nonzero count occupies the block and gives no immediate result.
  `LCG_ASSERT_NXT(a_busy_after, clk_i, rst_ni, accept && (step_count_i != '0), busy && !valid_o)
  // The unit only answers a multiply-add that the sequencer has in flight.
  `LCG_ASSERT_IMP(a_done_inflight, clk_i, rst_ni, mm_rsp.done, wait_q && busy)

endmodule

FILE: design/lcg_mulmod.sv
`timescale 1ns / 1ps

// Bit-serial modular multiply-add. The multiplicand bits are walked from the
// top down (Horner form): each bit doubles the residue, and a set bit adds a.
// A last pass adds c. One adder with a trial subtraction of m does all steps.
module lcg_mulmod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     m_i,
  input  lcg_pkg::mm_req_t req_i,
  output lcg_pkg::mm_rsp_t rsp_o
);
  import lcg_pkg::*;

  mm_state_e        state_q, state_d;
  logic [IDX_W-1:0] idx_q;
  logic [VAL_W-1:0] r_q, a_q, b_q, c_q;
  logic             done_q;

  logic [VAL_W-1:0] opnd;
  logic [VAL_W:0]   sum;
  logic [VAL_W+1:0] diff;
  logic [VAL_W-1:0] red;
  logic             last_bit;

  assign last_bit = (idx_q == '0);

  // Phase sequencing.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MM_IDLE: begin
        if (req_i.start) begin
          state_d = MM_DBL;
        end
      end
      MM_DBL: begin
        if (b_q[idx_q]) begin
          state_d = MM_ADD;
        end else if (last_bit) begin
          state_d = MM_ADDC;
        end
      end
      MM_ADD: begin
        state_d = last_bit ? MM_ADDC : MM_DBL;
      end
      MM_ADDC: begin
        state_d = MM_IDLE;
      end
    endcase
  end

  // Second adder operand for each phase.
  always_comb begin
    unique case (state_q)
      MM_IDLE: opnd = '0;
      MM_DBL:  opnd = r_q;
      MM_ADD:  opnd = a_q;
      MM_ADDC: opnd = c_q;
    endcase
  end

  // Shared add and conditional subtract of the modulus.
  assign sum  = {1'b0, r_q} + {1'b0, opnd};
  assign diff = {1'b0, sum} - {1'b0, m_i};
  assign red  = diff[VAL_W+1] ? sum[VAL_W-1:0] : diff[VAL_W-1:0];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MM_ADDC);
    end
  end

  // Operand and residue registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MM_IDLE: begin
        if (req_i.start) begin
          a_q   <= req_i.a;
          b_q   <= req_i.b;
          c_q   <= req_i.c;
          r_q   <= '0;
          idx_q <= IDX_W'(VAL_W - 1);
        end
      end
      MM_DBL: begin
        r_q <= red;
        if (!b_q[idx_q] && !last_bit) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      MM_ADD: begin
        r_q <= red;
        if (!last_bit) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      MM_ADDC: begin
        r_q <= red;
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.r    = r_q;

endmodule
